/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_RUN(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("run-time assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/core/crc32ws_pkg.sv */
package crc32ws_pkg;

    localparam int unsigned CRC_WIDTH = 32;

    localparam logic [CRC_WIDTH-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'h04C1_1DB7;

    typedef logic [CRC_WIDTH-1:0] crc_word_t;

    // fold one word into the crc, msb first; a fixed xor network once unrolled
    function automatic crc_word_t crc32ws_fold(input crc_word_t crc, input crc_word_t word);
        crc_word_t c;
        c = crc;
        for (int i = CRC_WIDTH - 1; i >= 0; i--) begin
            if (c[CRC_WIDTH-1] ^ word[i]) begin
                c = {c[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_WIDTH-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/crc32_word_stream_unit.sv */
// channel | dir | tdata (low bit up) | tuser | tlast
// s_      | in  | data_word [31:0]   | -     | last_word
// m_      | out | crc_value [31:0]   | -     | -
//
// one word accepted per cycle unless stalled, back to back, with no gaps between messages
// the last word of a message passes the input register, then is folded into
// the running crc and the result register, from which the crc leaves
// the 32 crc steps of a word unroll into one xor network between those registers
// aresetn (synchronous, active low) empties both stages and sets the crc to all ones
// a stalled result holds only the input stage once that holds a last word
module crc32_word_stream_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input channel
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  crc32ws_pkg::crc_word_t  s_tdata,   // [31:0] data_word
    input  logic                    s_tlast,   // last_word
    // result channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output crc32ws_pkg::crc_word_t  m_tdata    // [31:0] crc_value
);
    import crc32ws_pkg::*;

    // input stage
    logic      in_valid_reg;
    logic      in_valid_next;
    crc_word_t in_word_reg;
    logic      in_last_reg;

    // running crc
    crc_word_t crc_reg;
    crc_word_t crc_next;

    // result stage
    logic      out_valid_reg;
    logic      out_valid_next;
    crc_word_t out_crc_reg;

    crc_word_t folded;
    logic      s_accept;
    logic      advance;
    logic      out_free;

    // fold the held word into the running crc
    assign folded = crc32ws_fold(crc_reg, in_word_reg);

    // result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || m_tready;

    // a non-last word never needs the result register, so it never waits on it
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        crc_next = crc_reg;
        if (advance) begin
            // restart at all ones once a message is closed
            crc_next = in_last_reg ? CRC_INIT : folded;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_crc_reg <= folded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

endmodule

/* rtl/core/crc32ws_checker.sv */
`include "assert_macros.svh"

module crc32ws_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input crc32ws_pkg::crc_word_t  m_tdata
);
    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // reset empties the result stage
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid)

    // a result held back keeps its value
    `ASSERT_RUN(a_hold_data, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // a draining result register never blocks the input
    `ASSERT_RUN(a_ready_when_drained, aclk, aresetn, m_tready |-> s_tready)

    // no result appears from nowhere while none is shown and nothing is accepted
    `ASSERT_RUN(a_no_phantom, aclk, aresetn,
        (!m_tvalid && !s_acc) ##1 (!m_tvalid && !s_acc) |=> !m_tvalid)

endmodule

bind crc32_word_stream_unit crc32ws_checker u_crc32ws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
